[design/pts_pkg.sv]
package pts_pkg;

  // Bank geometry and tick length
  localparam int NUM_SLOTS = 16;
  localparam int TICK_MS   = 10;

  localparam int SLOT_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int LINK_W = SLOT_W + 1;
  localparam int CNT_W  = $clog2(NUM_SLOTS + 1);

  localparam logic [LINK_W-1:0] NO_LINK = {LINK_W{1'b1}};

  // Ceiling reciprocal of the tick length, scaled by 2^32. Exact floor
  // quotient for any 16-bit dividend and tick lengths up to 1000.
  localparam logic [32:0] RECIP =
    33'(((64'd1 << 32) + 64'(TICK_MS) - 64'd1) / 64'(TICK_MS));

  // Command codes
  localparam logic [1:0] CMD_TICK = 2'd0;
  localparam logic [1:0] CMD_REG  = 2'd1;
  localparam logic [1:0] CMD_READ = 2'd2;

  // Result kinds
  localparam logic [1:0] KIND_FIRED = 2'd0;
  localparam logic [1:0] KIND_REGD  = 2'd1;
  localparam logic [1:0] KIND_FULL  = 2'd2;
  localparam logic [1:0] KIND_CLOCK = 2'd3;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [15:0] period_ms;
    logic [15:0] repeat_limit;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [3:0]  slot;
    logic [31:0] now_ms;
    logic        last;
  } out_item_t;

  // Controller to datapath
  typedef struct packed {
    logic cap;
    logic start_walk;
    logic visit;
    logic flush;
    logic do_reg;
    logic do_read;
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic walk_done;
    logic fire;
    logic pending;
    logic out_free;
  } ctrl_stat_t;

  function automatic logic is_slot(input logic [LINK_W-1:0] l);
    return l < LINK_W'(NUM_SLOTS);
  endfunction

  function automatic logic [LINK_W-1:0] slot_link(input logic [SLOT_W-1:0] s);
    return {1'b0, s};
  endfunction

  function automatic logic [3:0] out_slot(input logic [SLOT_W-1:0] s);
    logic [7:0] w;
    w = 8'(s);
    return w[3:0];
  endfunction

  // period in ms -> period in ticks, at least one tick
  function automatic logic [15:0] period_to_ticks(input logic [15:0] ms);
    logic [48:0] prod;
    logic [15:0] q;
    prod = 49'(ms) * 49'(RECIP);
    q = prod[47:32];
    return (q == 16'd0) ? 16'd1 : q;
  endfunction

endpackage

[design/pts_ctrl.sv]
module pts_ctrl
  import pts_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       req_valid,
  input  logic [1:0] req_cmd,
  input  ctrl_stat_t stat,
  output ctrl_cmd_t  ctl,
  output logic       req_stall
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_WALK  = 3'd1;
  localparam logic [2:0] S_FLUSH = 3'd2;
  localparam logic [2:0] S_REG   = 3'd3;
  localparam logic [2:0] S_READ  = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;

  // Next state and command decode
  always_comb begin
    state_next = state;
    ctl = '0;
    case (state)
      S_IDLE: begin
        if (req_valid) begin
          ctl.cap = 1'b1;
          case (req_cmd)
            CMD_TICK: begin
              ctl.start_walk = 1'b1;
              state_next = S_WALK;
            end
            CMD_REG:  state_next = S_REG;
            CMD_READ: state_next = S_READ;
            default:  state_next = S_IDLE;
          endcase
        end
      end
      S_WALK: begin
        if (stat.walk_done) begin
          state_next = stat.pending ? S_FLUSH : S_IDLE;
        end else if (!(stat.fire && stat.pending && !stat.out_free)) begin
          ctl.visit = 1'b1;
        end
      end
      S_FLUSH: begin
        if (stat.out_free) begin
          ctl.flush = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_REG: begin
        if (stat.out_free) begin
          ctl.do_reg = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_READ: begin
        if (stat.out_free) begin
          ctl.do_read = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign req_stall = (state != S_IDLE);

endmodule

[design/pts_dp.sv]
module pts_dp
  import pts_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  in_item_t   req,
  input  ctrl_cmd_t  ctl,
  output ctrl_stat_t stat,
  input  logic       rsp_stall,
  output logic       rsp_valid,
  output out_item_t  rsp
);

  // Slot tables
  logic [NUM_SLOTS-1:0] busy;
  logic [15:0]          counter    [NUM_SLOTS];
  logic [15:0]          period     [NUM_SLOTS];
  logic [15:0]          limit_left [NUM_SLOTS];
  logic [LINK_W-1:0]    nxt        [NUM_SLOTS];
  logic [LINK_W-1:0]    prv        [NUM_SLOTS];

  logic [LINK_W-1:0] live_head;
  logic [CNT_W-1:0]  live_count;
  logic [31:0]       clock_ms;

  // Walk position and held-back fired slot
  logic [LINK_W-1:0] idx;
  logic [CNT_W-1:0]  steps;
  logic              pend_valid;
  logic [SLOT_W-1:0] pend_slot;

  // Captured item
  logic [15:0] period_ms_q;
  logic [15:0] limit_q;

  logic [SLOT_W-1:0] cur;
  logic [15:0]       cur_cnt;
  logic [15:0]       cur_lim;
  logic [LINK_W-1:0] cur_prev;
  logic [LINK_W-1:0] cur_next;
  logic              fire;
  logic              expire;
  logic              free_found;
  logic [SLOT_W-1:0] free_slot;
  logic              bank_full;
  logic [15:0]       ticks;
  logic              out_free;
  logic              out_load;
  out_item_t         out_next;

  // Current slot of the walk
  assign cur      = idx[SLOT_W-1:0];
  assign cur_cnt  = counter[cur];
  assign cur_lim  = limit_left[cur];
  assign cur_prev = prv[cur];
  assign cur_next = nxt[cur];
  assign fire     = (cur_cnt == 16'd0);
  assign expire   = fire && (cur_lim == 16'd1);

  // Lowest free slot
  always_comb begin
    free_found = 1'b0;
    free_slot  = '0;
    for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
      if (!busy[i]) begin
        free_found = 1'b1;
        free_slot  = SLOT_W'(i);
      end
    end
  end

  assign bank_full = (live_count >= CNT_W'(NUM_SLOTS)) || !free_found;
  assign ticks     = period_to_ticks(period_ms_q);
  assign out_free  = !rsp_valid || !rsp_stall;

  assign stat.walk_done = !is_slot(idx) || (steps == CNT_W'(NUM_SLOTS));
  assign stat.fire      = fire;
  assign stat.pending   = pend_valid;
  assign stat.out_free  = out_free;

  // Result selection
  always_comb begin
    out_load        = 1'b0;
    out_next.kind   = KIND_FIRED;
    out_next.slot   = out_slot(pend_slot);
    out_next.now_ms = clock_ms;
    out_next.last   = 1'b0;
    if (ctl.visit && fire && pend_valid) begin
      out_load = 1'b1;
    end
    if (ctl.flush) begin
      out_load      = 1'b1;
      out_next.last = 1'b1;
    end
    if (ctl.do_reg) begin
      out_load      = 1'b1;
      out_next.last = 1'b1;
      if (bank_full) begin
        out_next.kind = KIND_FULL;
        out_next.slot = 4'd0;
      end else begin
        out_next.kind = KIND_REGD;
        out_next.slot = out_slot(free_slot);
      end
    end
    if (ctl.do_read) begin
      out_load      = 1'b1;
      out_next.kind = KIND_CLOCK;
      out_next.slot = 4'd0;
      out_next.last = 1'b1;
    end
  end

  // State and tables
  always_ff @(posedge clk) begin
    if (rst) begin
      busy       <= '0;
      live_head  <= NO_LINK;
      live_count <= '0;
      clock_ms   <= '0;
      idx        <= NO_LINK;
      steps      <= '0;
      pend_valid <= 1'b0;
      rsp_valid  <= 1'b0;
    end else begin
      if (out_load) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end

      if (ctl.cap) begin
        period_ms_q <= req.period_ms;
        limit_q     <= req.repeat_limit;
      end

      if (ctl.start_walk) begin
        clock_ms <= clock_ms + 32'(TICK_MS);
        idx      <= live_head;
        steps    <= '0;
      end

      // one live slot per cycle, unless a fired slot must wait for a full output register
      if (ctl.visit) begin
        counter[cur] <= fire ? (period[cur] - 16'd1) : (cur_cnt - 16'd1);
        if (fire) begin
          pend_valid <= 1'b1;
          pend_slot  <= cur;
          if (cur_lim != 16'd0) begin
            limit_left[cur] <= cur_lim - 16'd1;
          end
        end
        if (expire) begin
          busy[cur] <= 1'b0;
          if (live_count != '0) begin
            live_count <= live_count - CNT_W'(1);
          end
          if (is_slot(cur_prev)) begin
            nxt[cur_prev[SLOT_W-1:0]] <= cur_next;
          end else begin
            live_head <= cur_next;
          end
          if (is_slot(cur_next)) begin
            prv[cur_next[SLOT_W-1:0]] <= cur_prev;
          end
        end
        idx   <= cur_next;
        steps <= steps + CNT_W'(1);
      end

      if (ctl.flush) begin
        pend_valid <= 1'b0;
      end

      // new timer goes to the front of the live list
      if (ctl.do_reg && !bank_full) begin
        live_count         <= live_count + CNT_W'(1);
        busy[free_slot]    <= 1'b1;
        prv[free_slot]     <= NO_LINK;
        nxt[free_slot]     <= live_head;
        if (is_slot(live_head)) begin
          prv[live_head[SLOT_W-1:0]] <= slot_link(free_slot);
        end
        live_head          <= slot_link(free_slot);
        period[free_slot]  <= ticks;
        counter[free_slot] <= ticks;
        limit_left[free_slot] <= limit_q;
      end
    end
  end

  // Output register payload
  always_ff @(posedge clk) begin
    if (out_load) begin
      rsp <= out_next;
    end
  end

endmodule

[design/periodic_timer_slot_bank.sv]
// Register and read-clock items: one result, loaded into the output register
// once it is free; the next item is taken after the block returns to idle.
// Tick items: the item is taken, the walk visits each live slot in list
// order, the walk closes, and the last fired slot is pushed out; that final
// push is skipped when nothing fires.
// Reset (rst, synchronous): every slot free, live list empty, clock at zero.
module periodic_timer_slot_bank
  import pts_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      req_valid,
  output logic      req_stall,
  input  in_item_t  req,
  output logic      rsp_valid,
  input  logic      rsp_stall,
  output out_item_t rsp
);

  ctrl_cmd_t  ctl;
  ctrl_stat_t stat;

  pts_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_cmd   (req.cmd),
    .stat      (stat),
    .ctl       (ctl),
    .req_stall (req_stall)
  );

  pts_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .ctl       (ctl),
    .stat      (stat),
    .rsp_stall (rsp_stall),
    .rsp_valid (rsp_valid),
    .rsp       (rsp)
  );

`ifndef SYNTHESIS
  // a new item never enters while a fired slot is still held back
  a_no_accept_pending: assert property (@(posedge clk) disable iff (rst)
    (req_valid && !req_stall) |-> !stat.pending)
    else $error("item taken while a fired slot is pending");

  // a visit that pushes out a held result needs a free output register
  a_visit_room: assert property (@(posedge clk) disable iff (rst)
    (ctl.visit && stat.fire && stat.pending) |-> stat.out_free)
    else $error("fired result pushed into a full output register");

  // datapath commands are mutually exclusive
  a_cmd_onehot: assert property (@(posedge clk) disable iff (rst)
    $onehot0({ctl.cap, ctl.visit, ctl.flush, ctl.do_reg, ctl.do_read}))
    else $error("overlapping datapath commands");

  // a read item keeps the block busy in the following cycle
  a_read_busy: assert property (@(posedge clk) disable iff (rst)
    (req_valid && !req_stall && req.cmd == CMD_READ) |=> req_stall)
    else $error("read item did not occupy the block");
`endif

endmodule
